/* rtl/value_noise_two_octave_macros.svh */
// Assertion macros for the two-octave value noise block.
// Used by the checker module bound to the top level.
`ifndef VALUE_NOISE_TWO_OCTAVE_MACROS_SVH
`define VALUE_NOISE_TWO_OCTAVE_MACROS_SVH
// Implication checked on every clock, masked during reset.
`define VN_ASSERT(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
// Implication checked on every clock, reset cycles included.
`define VN_ASSERT_ALWAYS(label, clk_s, prop, msg) \
  label: assert property (@(posedge clk_s) prop) else $error(msg);
`endif

/* rtl/vnoise_pkg.sv */
// Shared constants and hash helpers for the two-octave value noise block.
// No dependencies.
`timescale 1ns / 1ps
package vnoise_pkg;
  localparam int FractionBitsDefault = 16;
  localparam logic [31:0] BaseFreqReset   = 32'd335544;
  localparam logic [31:0] DetailFreqReset = 32'd905969;
  localparam logic [31:0] DetailSeedMask  = 32'h5bd1e995;
  localparam logic [31:0] HashMulA = 32'h7feb352d;
  localparam logic [31:0] HashMulB = 32'h846ca68b;
  localparam logic [31:0] IxMul    = 32'h9E3779B9;
  localparam logic [31:0] IzMul    = 32'h85EBCA6B;
  localparam logic [23:0] WeightOne = 24'd10905190;
  localparam logic [23:0] WeightTwo = 24'd5872026;
  localparam logic [1:0] RegSeed   = 2'd0;
  localparam logic [1:0] RegBase   = 2'd1;
  localparam logic [1:0] RegDetail = 2'd2;

  // first half of mix32: xor-shift then multiply
  function automatic logic [31:0] mix_a(input logic [31:0] v);
    logic [31:0] w;
    begin
      w = v ^ (v >> 16);
      return w * HashMulA;
    end
  endfunction

  // second half of mix32
  function automatic logic [31:0] mix_b(input logic [31:0] v);
    logic [31:0] w;
    begin
      w = v ^ (v >> 15);
      w = w * HashMulB;
      return w ^ (w >> 16);
    end
  endfunction
endpackage

/* rtl/vnoise_octave.sv */
// One octave of hashed value noise, fully pipelined with shared enable.
// Depends on vnoise_pkg.
`timescale 1ns / 1ps
module vnoise_octave #(
  parameter int FractionBits = vnoise_pkg::FractionBitsDefault
) (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] seed,
  input  logic [31:0] freq,
  input  logic [31:0] x_in,
  input  logic [31:0] z_in,
  output logic [23:0] value
);
  import vnoise_pkg::*;
  localparam int F = FractionBits;
  localparam logic [F+1:0] Three = (F+2)'(3) << F;
  localparam logic [F:0] One = (F+1)'(1) << F;

  // S1: coordinate times frequency, split in 16-bit partial products
  logic signed [48:0] xlo, xhi, zlo, zhi;
  always_ff @(posedge clk) begin
    if (en) begin
      xlo <= $signed(x_in) * $signed({1'b0, freq[15:0]});
      xhi <= $signed(x_in) * $signed({1'b0, freq[31:16]});
      zlo <= $signed(z_in) * $signed({1'b0, freq[15:0]});
      zhi <= $signed(z_in) * $signed({1'b0, freq[31:16]});
    end
  end
  logic signed [63:0] px, pz;
  assign px = 64'(xlo) + (64'(xhi) <<< 16);
  assign pz = 64'(zlo) + (64'(zhi) <<< 16);

  // S2: index (floor, sign-extended to 32 bits) and fraction
  logic [31:0] ix2, iz2;
  logic [F-1:0] tx2, tz2;
  always_ff @(posedge clk) begin
    if (en) begin
      ix2 <= {{8{px[63]}}, px[63:40]};
      iz2 <= {{8{pz[63]}}, pz[63:40]};
      tx2 <= px[39:40-F];
      tz2 <= pz[39:40-F];
    end
  end

  // S3: t squared, inner hash first multiply
  logic [F-1:0] tx3, tz3, qx3, qz3;
  logic [31:0] ix3, hz0_3, hz1_3;
  logic [2*F-1:0] sqx, sqz;
  assign sqx = tx2 * tx2;
  assign sqz = tz2 * tz2;
  always_ff @(posedge clk) begin
    if (en) begin
      tx3 <= tx2; tz3 <= tz2; ix3 <= ix2;
      qx3 <= sqx[2*F-1:F]; qz3 <= sqz[2*F-1:F];
      hz0_3 <= iz2 * IzMul;
      hz1_3 <= (iz2 + 32'd1) * IzMul;
    end
  end

  // S4: smoothstep product, inner mix A
  logic [F-1:0] sx4, sz4;
  logic [2*F+1:0] smx, smz;
  logic [31:0] ix4, mz0_4, mz1_4;
  assign smx = qx3 * (Three - {tx3, 1'b0});
  assign smz = qz3 * (Three - {tz3, 1'b0});
  always_ff @(posedge clk) begin
    if (en) begin
      sx4 <= smx[2*F-1:F]; sz4 <= smz[2*F-1:F]; ix4 <= ix3;
      mz0_4 <= mix_a(hz0_3 ^ seed);
      mz1_4 <= mix_a(hz1_3 ^ seed);
    end
  end

  // S5: inner mix B, x products
  logic [F-1:0] sx5, sz5;
  logic [31:0] in0_5, in1_5, hx0_5, hx1_5;
  always_ff @(posedge clk) begin
    if (en) begin
      sx5 <= sx4; sz5 <= sz4;
      in0_5 <= mix_b(mz0_4);
      in1_5 <= mix_b(mz1_4);
      hx0_5 <= ix4 * IxMul;
      hx1_5 <= (ix4 + 32'd1) * IxMul;
    end
  end

  // S6: outer mix A for the four corners
  logic [F-1:0] sx6, sz6;
  logic [31:0] ma6, mb6, mc6, md6;
  always_ff @(posedge clk) begin
    if (en) begin
      sx6 <= sx5; sz6 <= sz5;
      ma6 <= mix_a(hx0_5 ^ in0_5);
      mb6 <= mix_a(hx1_5 ^ in0_5);
      mc6 <= mix_a(hx0_5 ^ in1_5);
      md6 <= mix_a(hx1_5 ^ in1_5);
    end
  end

  // S7: outer mix B, keep 24 bits
  logic [F-1:0] sx7, sz7;
  logic [23:0] a7, b7, c7, d7;
  logic [31:0] ha, hb, hc, hd;
  assign ha = mix_b(ma6);
  assign hb = mix_b(mb6);
  assign hc = mix_b(mc6);
  assign hd = mix_b(md6);
  always_ff @(posedge clk) begin
    if (en) begin
      sx7 <= sx6; sz7 <= sz6;
      a7 <= ha[23:0]; b7 <= hb[23:0]; c7 <= hc[23:0]; d7 <= hd[23:0];
    end
  end

  // S8: row blends along x
  logic [F-1:0] sz8;
  logic [23:0] r0_8, r1_8;
  logic [24+F:0] r0s, r1s;
  assign r0s = (25+F)'(a7 * (One - {1'b0, sx7})) + (25+F)'(b7 * sx7);
  assign r1s = (25+F)'(c7 * (One - {1'b0, sx7})) + (25+F)'(d7 * sx7);
  always_ff @(posedge clk) begin
    if (en) begin
      sz8 <= sz7;
      r0_8 <= r0s[F+23:F];
      r1_8 <= r1s[F+23:F];
    end
  end

  // S9: blend along z
  logic [24+F:0] vs;
  assign vs = (25+F)'(r0_8 * (One - {1'b0, sz8})) + (25+F)'(r1_8 * sz8);
  always_ff @(posedge clk) begin
    if (en) value <= vs[F+23:F];
  end
endmodule

/* rtl/value_noise_two_octave.sv */
// Two-octave value noise: accepted input beats leave the output register in order.
// Throughput one beat per cycle; the 9-stage datapath plus output register
// advance together whenever the output register is free or being taken.
// Reset: synchronous, clears valid bits and sets the configuration registers to their defaults.
// Depends on vnoise_pkg and vnoise_octave.
`timescale 1ns / 1ps
module value_noise_two_octave #(
  parameter int FractionBits = vnoise_pkg::FractionBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [31:0] x_coord,
  input  logic signed [31:0] z_coord,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] noise_value
);
  import vnoise_pkg::*;
  localparam int Depth = 9;

  logic [31:0] lattice_seed, base_frequency, detail_frequency;
  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      lattice_seed <= '0;
      base_frequency <= BaseFreqReset;
      detail_frequency <= DetailFreqReset;
    end else if (cfg_we) begin
      case (cfg_index)
        RegSeed:   lattice_seed <= cfg_data;
        RegBase:   base_frequency <= cfg_data;
        RegDetail: detail_frequency <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipe moves when the final stage can drain
  logic adv;
  logic [Depth-1:0] vld;
  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[Depth-2:0], in_valid};
  end

  logic [23:0] n1, n2;
  vnoise_octave #(.FractionBits(FractionBits)) u_oct1 (
    .clk, .en(adv), .seed(lattice_seed), .freq(base_frequency),
    .x_in(x_coord), .z_in(z_coord), .value(n1));
  vnoise_octave #(.FractionBits(FractionBits)) u_oct2 (
    .clk, .en(adv), .seed(lattice_seed ^ DetailSeedMask), .freq(detail_frequency),
    .x_in(x_coord), .z_in(z_coord), .value(n2));

  // weighted sum into output register; weights add to 2^24 so no overflow
  logic [47:0] wsum;
  assign wsum = 48'(n1 * WeightOne) + 48'(n2 * WeightTwo);
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= vld[Depth-1];
  end
  always_ff @(posedge clk) begin
    if (adv) noise_value <= wsum[47:24];
  end
endmodule

/* rtl/vnoise_checker.sv */
// Port-level checker for value_noise_two_octave, bound to the top level.
// Depends on value_noise_two_octave_macros.svh.
`timescale 1ns / 1ps
`include "value_noise_two_octave_macros.svh"
module vnoise_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [23:0] noise_value
);
  `VN_ASSERT(a_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(noise_value), "stalled beat changed")
  `VN_ASSERT(a_stall, clk, rst, in_stall |-> out_valid && out_stall, "input stalled without back pressure")
  `VN_ASSERT(a_idle, clk, rst, !out_valid |-> !in_stall, "stall while output register empty")
  `VN_ASSERT_ALWAYS(a_rst_clear, clk, rst |=> !out_valid, "output valid after reset")
endmodule

bind value_noise_two_octave vnoise_checker u_vnoise_checker (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .noise_value);

/* tb/tb_value_noise_two_octave.sv */
// Self-checking bench for the two-octave value noise block.
// Holds its own bit-true noise predictor; depends on vnoise_pkg and the block.
`timescale 1ns / 1ps
module tb_value_noise_two_octave;
  import vnoise_pkg::*;

  localparam logic [1:0] RegUnused = 2'd3;
  localparam int PhaseCount = 6;
  localparam int PointsPerPhase = 256;
  localparam int LongHoldCycles = 300;
  localparam int DrainCycles = 16;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic signed [31:0] x_coord;
  logic signed [31:0] z_coord;
  logic out_valid;
  logic out_stall;
  logic [23:0] noise_value;

  value_noise_two_octave i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .x_coord(x_coord), .z_coord(z_coord),
    .out_valid(out_valid), .out_stall(out_stall),
    .noise_value(noise_value)
  );

  // mirror of the register file
  logic [31:0] seed_q;
  logic [31:0] base_freq_q;
  logic [31:0] detail_freq_q;

  logic [23:0] pending_noise[$];
  int errors;
  int points_sent;
  int results_seen;
  bit idle_on;
  bit long_hold;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] z;
  } point_t;

  // directed points: origin, sign and range extremes, cell edges, bit patterns.
  // Hashed corner values cannot be read off by eye, so every row goes
  // through the predictor.
  point_t directed_points[12] = '{
    '{32'h0000_0000, 32'h0000_0000},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{32'h8000_0000, 32'h8000_0000},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF},
    '{32'h8000_0000, 32'h7FFF_FFFF},
    '{32'h7FFF_FFFF, 32'h8000_0000},
    '{32'h0001_0000, 32'h0000_0000},
    '{32'h0000_0000, 32'hFFFF_0000},
    '{32'h0000_FFFF, 32'h0000_0001},
    '{32'hAAAA_AAAA, 32'h5555_5555},
    '{32'h5555_5555, 32'hAAAA_AAAA},
    '{32'h0032_0000, 32'hFFCE_0000}
  };

  // integer avalanche used by the lattice hash
  function automatic logic [31:0] scramble(input logic [31:0] v);
    logic [31:0] w;
    w = v ^ (v >> 16);
    w = w * 32'h7feb352d;
    w = w ^ (w >> 15);
    w = w * 32'h846ca68b;
    return w ^ (w >> 16);
  endfunction

  function automatic logic [63:0] lattice_value(input logic [31:0] seed,
                                                input logic [31:0] ix,
                                                input logic [31:0] iz);
    logic [31:0] row_hash;
    logic [31:0] h;
    row_hash = scramble((iz * 32'h85EBCA6B) ^ seed);
    h = scramble((ix * 32'h9E3779B9) ^ row_hash);
    return {40'd0, h[23:0]};
  endfunction

  // coordinate times frequency -> lattice index and smoothstepped fraction
  function automatic void split_axis(input logic [31:0] coord, input logic [31:0] freq,
                                     output logic [31:0] idx, output logic [63:0] s);
    logic [63:0] prod;
    logic [63:0] t;
    logic [63:0] t2;
    prod = {{32{coord[31]}}, coord} * {32'd0, freq};
    idx = {{8{prod[63]}}, prod[63:40]};
    t = {48'd0, prod[39:24]};
    t2 = (t * t) >> 16;
    s = (t2 * (64'd3 * 64'd65536 - 64'd2 * t)) >> 16;
  endfunction

  function automatic logic [63:0] octave_noise(input logic [31:0] seed,
                                               input logic [31:0] x, input logic [31:0] z,
                                               input logic [31:0] freq);
    logic [31:0] ix;
    logic [31:0] iz;
    logic [63:0] sx;
    logic [63:0] sz;
    logic [63:0] row0;
    logic [63:0] row1;
    logic [63:0] one;
    one = 64'd65536;
    split_axis(x, freq, ix, sx);
    split_axis(z, freq, iz, sz);
    row0 = (lattice_value(seed, ix, iz) * (one - sx)
            + lattice_value(seed, ix + 32'd1, iz) * sx) >> 16;
    row1 = (lattice_value(seed, ix, iz + 32'd1) * (one - sx)
            + lattice_value(seed, ix + 32'd1, iz + 32'd1) * sx) >> 16;
    return (row0 * (one - sz) + row1 * sz) >> 16;
  endfunction

  function automatic logic [23:0] predict_noise(input logic [31:0] x, input logic [31:0] z);
    logic [63:0] n1;
    logic [63:0] n2;
    logic [63:0] sum;
    n1 = octave_noise(seed_q, x, z, base_freq_q);
    n2 = octave_noise(seed_q ^ 32'h5bd1e995, x, z, detail_freq_q);
    sum = (n1 * 64'd10905190 + n2 * 64'd5872026) >> 24;
    return sum[23:0];
  endfunction

  // mix of origin neighborhood, cell edges, extremes and full range
  function automatic logic [31:0] pick_coord();
    logic [31:0] extremes[5] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                                 32'hFFFF_0000};
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3: return extremes[$urandom_range(0, 4)];
      4: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
    endcase
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // overall time limit
  initial begin
    #10ms;
    $display("tb: failure");
    $finish;
  end

  // register write; called at a rising edge, also updates the register mirror
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegSeed: seed_q = data;
      RegBase: base_freq_q = data;
      RegDetail: detail_freq_q = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // offer one beat and hold it until taken; decide acceptance at the falling edge
  task automatic send_point(input logic [31:0] x, input logic [31:0] z);
    bit taken;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    x_coord <= x;
    z_coord <= z;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      if (taken) pending_noise.push_back(predict_noise(x, z));
      @(posedge clk);
    end
    points_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_noise.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // output side stall pattern, including one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (LongHoldCycles) @(posedge clk);
        long_hold = 1'b0;
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // result checker: beat is taken at the next rising edge
  initial begin
    logic [23:0] want;
    forever begin
      @(negedge clk);
      if (!rst && out_valid && !out_stall) begin
        results_seen++;
        if (pending_noise.size() == 0) begin
          $error("unexpected beat: noise_value actual %h", noise_value);
          errors++;
        end else begin
          want = pending_noise.pop_front();
          if (noise_value !== want) begin
            $error("noise_value mismatch: expected %h actual %h", want, noise_value);
            errors++;
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    errors = 0;
    points_sent = 0;
    results_seen = 0;
    idle_on = 1'b1;
    long_hold = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = RegSeed;
    cfg_data = '0;
    in_valid = 1'b0;
    x_coord = '0;
    z_coord = '0;
    seed_q = 32'd0;
    base_freq_q = BaseFreqReset;
    detail_freq_q = DetailFreqReset;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int phase = 0; phase < PhaseCount; phase++) begin
      if (phase > 0) wait_idle();
      case (phase)
        0: begin
          // reset defaults, directed points first
          foreach (directed_points[i]) send_point(directed_points[i].x, directed_points[i].z);
        end
        1: begin
          // zero frequency: every point lands on cell zero; unknown index ignored
          write_reg(RegSeed, 32'hFFFF_FFFF);
          write_reg(RegBase, 32'd0);
          write_reg(RegDetail, 32'd0);
          write_reg(RegUnused, $urandom);
        end
        2: begin
          write_reg(RegSeed, 32'd0);
          write_reg(RegBase, 32'hFFFF_FFFF);
          write_reg(RegDetail, 32'hFFFF_FFFF);
        end
        3: begin
          write_reg(RegSeed, $urandom);
          write_reg(RegBase, 32'h0100_0000);
          write_reg(RegDetail, 32'h02B3_3333);
        end
        4: begin
          write_reg(RegSeed, $urandom);
          write_reg(RegBase, $urandom);
          write_reg(RegDetail, $urandom);
        end
        default: begin
          write_reg(RegSeed, $urandom);
          write_reg(RegBase, $urandom_range(0, 32'h0010_0000));
          write_reg(RegDetail, base_freq_q * 27 / 10);
        end
      endcase

      for (int n = 0; n < PointsPerPhase; n++) begin
        // receiver blocks for a long stretch while points keep coming
        if (phase == 2 && n == 20) long_hold = 1'b1;
        // sender waits for the pipe to empty once
        if (phase == 3 && n == 100) wait_idle();
        // final stretch runs back to back
        if (phase == PhaseCount - 1 && n == PointsPerPhase / 2) idle_on = 1'b0;
        send_point(pick_coord(), pick_coord());
      end
    end

    in_valid <= 1'b0;
    while (pending_noise.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (pending_noise.size() != 0) errors++;

    $display("tb: %0d points over %0d register settings, %0d results checked, %0d errors",
             points_sent, PhaseCount, results_seen, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/vnoise_pkg.sv
rtl/vnoise_octave.sv
rtl/value_noise_two_octave.sv
rtl/vnoise_checker.sv
tb/tb_value_noise_two_octave.sv
